>>> rtl/core/ssd_pkg.sv
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared constants for the 3D segment-to-segment distance pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package ssd_pkg;

  localparam int unsigned NUM_COORDS          = 12;
  localparam int unsigned COORD_BITS_DEF      = 16;
  localparam int unsigned PARAM_FRAC_BITS_DEF = 16;
  localparam int unsigned OUT_FRAC_BITS_DEF   = 8;

  // result field and its byte-padded bus
  localparam int unsigned DIST_BITS     = 26;
  localparam int unsigned OUT_DATA_BITS = 32;

endpackage

`default_nettype wire

>>> rtl/core/segment_segment_distance_3d.sv
// ----------------------------------------------------------------------------
// segment_segment_distance_3d
// Distance between two 3D line segments, fully pipelined.
// ----------------------------------------------------------------------------
// Takes one segment pair per clock and returns one distance per pair, in
// order. Data passes through setup, the s/t dividers, the distance stage,
// the square root and the output register: the s/t dividers give one
// quotient bit per stage and the square root one result bit per stage. The
// whole pipe advances together; it stalls only while a result sits in the
// output register and m_tready is low. Distance is floor(sqrt), unsigned,
// OUT_FRAC_BITS fraction bits, saturated to 26 bits.
`default_nettype none

module segment_segment_distance_3d #(
  parameter int unsigned COORD_BITS      = ssd_pkg::COORD_BITS_DEF,
  parameter int unsigned PARAM_FRAC_BITS = ssd_pkg::PARAM_FRAC_BITS_DEF,
  parameter int unsigned OUT_FRAC_BITS   = ssd_pkg::OUT_FRAC_BITS_DEF,
  parameter int unsigned IN_DATA_BITS    = ((ssd_pkg::NUM_COORDS * COORD_BITS + 7) / 8) * 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  // first_start_x/y/z, first_end_x/y/z, second_start_x/y/z, second_end_x/y/z
  input  wire logic [IN_DATA_BITS-1:0]             s_tdata,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  // closest_distance
  output logic [ssd_pkg::OUT_DATA_BITS-1:0]        m_tdata
);

  localparam int unsigned DW  = COORD_BITS + 1;
  localparam int unsigned PW  = 2 * DW + 2;
  localparam int unsigned NW  = 2 * PW;
  localparam int unsigned QW  = PARAM_FRAC_BITS + 1;
  localparam int unsigned RW  = DW + 4 + OUT_FRAC_BITS;
  localparam int unsigned XW  = 9 * DW;
  localparam int unsigned DB  = ssd_pkg::DIST_BITS;
  localparam logic [QW-1:0] ONE = QW'(1) << PARAM_FRAC_BITS;

  logic ce;
  assign ce       = !m_tvalid || m_tready;
  assign s_tready = ce;

  logic                 setup_vld;
  logic signed [NW-1:0] s_num, s_den, t_num, t_den;
  logic [XW-1:0]        uvw_a, uvw_b;

  ssd_setup #(
    .COORD_BITS (COORD_BITS),
    .DW         (DW),
    .PW         (PW),
    .NW         (NW)
  ) u_setup (
    .clk    (clk),
    .rst    (rst),
    .ce     (ce),
    .in_vld (s_tvalid),
    .coords (s_tdata[ssd_pkg::NUM_COORDS*COORD_BITS-1:0]),
    .vld    (setup_vld),
    .s_num  (s_num),
    .s_den  (s_den),
    .t_num  (t_num),
    .t_den  (t_den),
    .uvw    (uvw_a)
  );

  logic          div_vld;
  logic [QW-1:0] sc, tc;

  ssd_div #(
    .NW              (NW),
    .PARAM_FRAC_BITS (PARAM_FRAC_BITS),
    .XW              (XW),
    .QW              (QW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .ce       (ce),
    .in_vld   (setup_vld),
    .s_num    (s_num),
    .s_den    (s_den),
    .t_num    (t_num),
    .t_den    (t_den),
    .side_in  (uvw_a),
    .vld      (div_vld),
    .sc       (sc),
    .tc       (tc),
    .side_out (uvw_b)
  );

  logic            dist_vld;
  logic [2*RW-1:0] sq_len;

  ssd_dist #(
    .DW              (DW),
    .PARAM_FRAC_BITS (PARAM_FRAC_BITS),
    .OUT_FRAC_BITS   (OUT_FRAC_BITS),
    .QW              (QW),
    .SQW             (2 * RW)
  ) u_dist (
    .clk    (clk),
    .rst    (rst),
    .ce     (ce),
    .in_vld (div_vld),
    .sc     (sc),
    .tc     (tc),
    .uvw    (uvw_b),
    .vld    (dist_vld),
    .sq_len (sq_len)
  );

  logic          root_vld;
  logic [RW-1:0] root;

  ssd_sqrt #(
    .RW (RW)
  ) u_sqrt (
    .clk    (clk),
    .rst    (rst),
    .ce     (ce),
    .in_vld (dist_vld),
    .rad    (sq_len),
    .vld    (root_vld),
    .root   (root)
  );

  logic [DB-1:0] dist_sat;
  always_comb begin
    if ((RW > DB) && ((root >> DB) != '0)) begin
      dist_sat = '1;
    end else begin
      dist_sat = DB'(root);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ce) begin
      m_tvalid <= root_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      m_tdata <= ssd_pkg::OUT_DATA_BITS'(dist_sat);
    end
  end

  // parameters never exceed one
  a_param_range: assert property (@(posedge clk) disable iff (rst)
    div_vld |-> (sc <= ONE) && (tc <= ONE))
    else $error("s or t above one");

  // a stalled pipe holds its valid pattern
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !ce |=> $stable(div_vld) && $stable(dist_vld) && $stable(root_vld))
    else $error("pipeline moved during stall");

  // pad bits above the distance stay clear
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata >> DB) == '0)
    else $error("output pad bits set");

endmodule

`default_nettype wire

>>> rtl/core/ssd_setup.sv
// ----------------------------------------------------------------------------
// ssd_setup
// Edge vectors, dot products, determinant and the clamped s/t fractions.
// Seven register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module ssd_setup #(
  parameter int unsigned COORD_BITS = ssd_pkg::COORD_BITS_DEF,
  parameter int unsigned DW         = COORD_BITS + 1,
  parameter int unsigned PW         = 2 * DW + 2,
  parameter int unsigned NW         = 2 * PW
) (
  input  wire logic                                       clk,
  input  wire logic                                       rst,
  input  wire logic                                       ce,
  input  wire logic                                       in_vld,
  input  wire logic [ssd_pkg::NUM_COORDS*COORD_BITS-1:0]  coords,
  output logic                                            vld,
  output logic signed [NW-1:0]                            s_num,
  output logic signed [NW-1:0]                            s_den,
  output logic signed [NW-1:0]                            t_num,
  output logic signed [NW-1:0]                            t_den,
  output logic [9*DW-1:0]                                 uvw
);

  localparam int unsigned NST = 7;
  localparam int unsigned MW  = 2 * DW;

  logic [NST-1:0]   vld_sr;
  logic [9*DW-1:0]  uvw_d [NST];

  logic signed [COORD_BITS-1:0] cin [ssd_pkg::NUM_COORDS];
  logic signed [DW-1:0] u1 [3];
  logic signed [DW-1:0] v1 [3];
  logic signed [DW-1:0] w1 [3];

  always_comb begin
    for (int k = 0; k < ssd_pkg::NUM_COORDS; k++) begin
      cin[k] = coords[k*COORD_BITS +: COORD_BITS];
    end
    for (int i = 0; i < 3; i++) begin
      u1[i] = DW'(cin[3+i]) - DW'(cin[i]);
      v1[i] = DW'(cin[9+i]) - DW'(cin[6+i]);
      w1[i] = DW'(cin[i])   - DW'(cin[6+i]);
    end
  end

  // stage 1: difference vectors, packed u | v | w
  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        uvw_d[0][i*DW +: DW]     <= u1[i];
        uvw_d[0][(3+i)*DW +: DW] <= v1[i];
        uvw_d[0][(6+i)*DW +: DW] <= w1[i];
      end
      for (int k = 1; k < NST; k++) begin
        uvw_d[k] <= uvw_d[k-1];
      end
    end
  end

  // stage 2: component products uu uv vv uw vw
  logic signed [MW-1:0] pr [3][5];
  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        pr[i][0] <= $signed(uvw_d[0][i*DW +: DW])     * $signed(uvw_d[0][i*DW +: DW]);
        pr[i][1] <= $signed(uvw_d[0][i*DW +: DW])     * $signed(uvw_d[0][(3+i)*DW +: DW]);
        pr[i][2] <= $signed(uvw_d[0][(3+i)*DW +: DW]) * $signed(uvw_d[0][(3+i)*DW +: DW]);
        pr[i][3] <= $signed(uvw_d[0][i*DW +: DW])     * $signed(uvw_d[0][(6+i)*DW +: DW]);
        pr[i][4] <= $signed(uvw_d[0][(3+i)*DW +: DW]) * $signed(uvw_d[0][(6+i)*DW +: DW]);
      end
    end
  end

  // stage 3: dot products a b c d e
  logic signed [PW-1:0] dp [5];
  always_ff @(posedge clk) begin
    if (ce) begin
      for (int j = 0; j < 5; j++) begin
        dp[j] <= PW'(pr[0][j]) + PW'(pr[1][j]) + PW'(pr[2][j]);
      end
    end
  end

  // stage 4: cross products of the dot products
  logic signed [PW-1:0] a4, b4, c4, d4, e4;
  logic signed [NW-1:0] ac4, bb4, be4, cd4, ae4, bd4;
  always_ff @(posedge clk) begin
    if (ce) begin
      ac4 <= dp[0] * dp[2];
      bb4 <= dp[1] * dp[1];
      be4 <= dp[1] * dp[4];
      cd4 <= dp[2] * dp[3];
      ae4 <= dp[0] * dp[4];
      bd4 <= dp[1] * dp[3];
      a4  <= dp[0];
      b4  <= dp[1];
      c4  <= dp[2];
      d4  <= dp[3];
      e4  <= dp[4];
    end
  end

  // stage 5: determinant and unclamped numerators
  logic signed [PW-1:0] a5, b5, c5, d5, e5;
  logic signed [NW-1:0] det5, sn5, tn5;
  always_ff @(posedge clk) begin
    if (ce) begin
      det5 <= ac4 - bb4;
      sn5  <= be4 - cd4;
      tn5  <= ae4 - bd4;
      a5   <= a4;
      b5   <= b4;
      c5   <= c4;
      d5   <= d4;
      e5   <= e4;
    end
  end

  // stage 6: parallel case and s edge clamps
  logic signed [PW-1:0] a6, b6, d6;
  logic signed [NW-1:0] sn6, sd6, tn6, td6;
  logic signed [NW-1:0] sn6_next, sd6_next, tn6_next, td6_next;
  always_comb begin
    if (det5 <= 0) begin
      sn6_next = '0;
      sd6_next = NW'(1);
      tn6_next = NW'(e5);
      td6_next = NW'(c5);
    end else begin
      sd6_next = det5;
      td6_next = det5;
      sn6_next = sn5;
      tn6_next = tn5;
      if (sn5 < 0) begin
        sn6_next = '0;
        tn6_next = NW'(e5);
        td6_next = NW'(c5);
      end else if (sn5 > det5) begin
        sn6_next = det5;
        tn6_next = NW'(e5) + NW'(b5);
        td6_next = NW'(c5);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      sn6 <= sn6_next;
      sd6 <= sd6_next;
      tn6 <= tn6_next;
      td6 <= td6_next;
      a6  <= a5;
      b6  <= b5;
      d6  <= d5;
    end
  end

  // stage 7: t edge clamps with s recomputed on that edge
  logic signed [PW:0]   ex;
  logic signed [NW-1:0] sn7_next, sd7_next, tn7_next;
  logic                 edge_hit;
  always_comb begin
    edge_hit = 1'b0;
    ex       = '0;
    tn7_next = tn6;
    if (tn6 < 0) begin
      edge_hit = 1'b1;
      tn7_next = '0;
      ex       = -(PW+1)'(d6);
    end else if (tn6 > td6) begin
      edge_hit = 1'b1;
      tn7_next = td6;
      ex       = (PW+1)'(b6) - (PW+1)'(d6);
    end
    sn7_next = sn6;
    sd7_next = sd6;
    if (edge_hit) begin
      if (ex < 0) begin
        sn7_next = '0;
      end else if (ex > (PW+1)'(a6)) begin
        sn7_next = sd6;
      end else begin
        sn7_next = NW'(ex);
        sd7_next = NW'(a6);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s_num <= sn7_next;
      s_den <= sd7_next;
      t_num <= tn7_next;
      t_den <= td6;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_sr <= '0;
    end else if (ce) begin
      vld_sr <= {vld_sr[NST-2:0], in_vld};
    end
  end

  assign vld = vld_sr[NST-1];
  assign uvw = uvw_d[NST-1];

endmodule

`default_nettype wire

>>> rtl/core/ssd_div.sv
// ----------------------------------------------------------------------------
// ssd_div
// Pipelined restoring dividers for s and t, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ssd_div #(
  parameter int unsigned NW              = 72,
  parameter int unsigned PARAM_FRAC_BITS = ssd_pkg::PARAM_FRAC_BITS_DEF,
  parameter int unsigned XW              = 51,
  parameter int unsigned QW              = PARAM_FRAC_BITS + 1
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  ce,
  input  wire logic                  in_vld,
  input  wire logic signed [NW-1:0]  s_num,
  input  wire logic signed [NW-1:0]  s_den,
  input  wire logic signed [NW-1:0]  t_num,
  input  wire logic signed [NW-1:0]  t_den,
  input  wire logic [XW-1:0]         side_in,
  output logic                       vld,
  output logic [QW-1:0]              sc,
  output logic [QW-1:0]              tc,
  output logic [XW-1:0]              side_out
);

  localparam int unsigned PF  = PARAM_FRAC_BITS;
  localparam logic [QW-1:0] ONE = QW'(1) << PF;

  logic [PF:0]            vld_sr;
  logic [NW-1:0]          sn [PF+1];
  logic [NW-1:0]          sd [PF+1];
  logic [NW-1:0]          tn [PF+1];
  logic [NW-1:0]          td [PF+1];
  logic [PF-1:0]          sq [PF+1];
  logic [PF-1:0]          tq [PF+1];
  logic                   s_frc [PF+1];
  logic                   t_frc [PF+1];
  logic [QW-1:0]          s_fq [PF+1];
  logic [QW-1:0]          t_fq [PF+1];
  logic [XW-1:0]          side [PF+1];

  // entry stage: zero, negative and saturated quotients are settled here
  always_ff @(posedge clk) begin
    if (ce) begin
      s_frc[0] <= (s_num <= 0) || (s_den <= 0) || (s_num >= s_den);
      s_fq[0]  <= ((s_num <= 0) || (s_den <= 0)) ? '0 : ONE;
      t_frc[0] <= (t_num <= 0) || (t_den <= 0) || (t_num >= t_den);
      t_fq[0]  <= ((t_num <= 0) || (t_den <= 0)) ? '0 : ONE;
      sn[0]    <= s_num;
      sd[0]    <= s_den;
      tn[0]    <= t_num;
      td[0]    <= t_den;
      sq[0]    <= '0;
      tq[0]    <= '0;
      side[0]  <= side_in;
    end
  end

  for (genvar g = 0; g < PF; g++) begin : g_stage
    logic [NW-1:0] sn2, tn2;
    logic          s_ge, t_ge;
    // numerator stays below the positive denominator, so the doubled value fits
    assign sn2  = {sn[g][NW-2:0], 1'b0};
    assign tn2  = {tn[g][NW-2:0], 1'b0};
    assign s_ge = sn2 >= sd[g];
    assign t_ge = tn2 >= td[g];

    always_ff @(posedge clk) begin
      if (ce) begin
        sn[g+1]    <= s_ge ? sn2 - sd[g] : sn2;
        tn[g+1]    <= t_ge ? tn2 - td[g] : tn2;
        sq[g+1]    <= {sq[g][PF-2:0], s_ge};
        tq[g+1]    <= {tq[g][PF-2:0], t_ge};
        sd[g+1]    <= sd[g];
        td[g+1]    <= td[g];
        s_frc[g+1] <= s_frc[g];
        t_frc[g+1] <= t_frc[g];
        s_fq[g+1]  <= s_fq[g];
        t_fq[g+1]  <= t_fq[g];
        side[g+1]  <= side[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_sr <= '0;
    end else if (ce) begin
      vld_sr <= {vld_sr[PF-1:0], in_vld};
    end
  end

  assign vld      = vld_sr[PF];
  assign sc       = s_frc[PF] ? s_fq[PF] : {1'b0, sq[PF]};
  assign tc       = t_frc[PF] ? t_fq[PF] : {1'b0, tq[PF]};
  assign side_out = side[PF];

endmodule

`default_nettype wire

>>> rtl/core/ssd_dist.sv
// ----------------------------------------------------------------------------
// ssd_dist
// Closest-point difference vector and its rescaled squared length.
// Four register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module ssd_dist #(
  parameter int unsigned DW              = 17,
  parameter int unsigned PARAM_FRAC_BITS = ssd_pkg::PARAM_FRAC_BITS_DEF,
  parameter int unsigned OUT_FRAC_BITS   = ssd_pkg::OUT_FRAC_BITS_DEF,
  parameter int unsigned QW              = PARAM_FRAC_BITS + 1,
  parameter int unsigned SQW             = 2 * DW + 8 + 2 * OUT_FRAC_BITS
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              ce,
  input  wire logic              in_vld,
  input  wire logic [QW-1:0]     sc,
  input  wire logic [QW-1:0]     tc,
  input  wire logic [9*DW-1:0]   uvw,
  output logic                   vld,
  output logic [SQW-1:0]         sq_len
);

  localparam int unsigned PF  = PARAM_FRAC_BITS;
  localparam int unsigned PW2 = DW + PF + 3;
  localparam int unsigned MW  = QW + 1 + DW;
  localparam int unsigned SW  = 2 * PW2 + 2;
  localparam int unsigned XW  = SW + 2 * OUT_FRAC_BITS;

  logic [3:0]            vld_sr;
  logic signed [MW-1:0]  su [3];
  logic signed [MW-1:0]  tv [3];
  logic signed [PW2-1:0] ws [3];
  logic signed [PW2-1:0] p  [3];
  logic [2*PW2-1:0]      pp [3];
  logic [SW-1:0]         sum;
  logic [XW-1:0]         ext;

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        su[i] <= $signed({1'b0, sc}) * $signed(uvw[i*DW +: DW]);
        tv[i] <= $signed({1'b0, tc}) * $signed(uvw[(3+i)*DW +: DW]);
        ws[i] <= PW2'($signed(uvw[(6+i)*DW +: DW])) <<< PF;
      end
      for (int i = 0; i < 3; i++) begin
        p[i] <= ws[i] + PW2'(su[i]) - PW2'(tv[i]);
      end
      for (int i = 0; i < 3; i++) begin
        pp[i] <= (2*PW2)'(p[i] * p[i]);
      end
    end
  end

  assign sum = SW'(pp[0]) + SW'(pp[1]) + SW'(pp[2]);
  // move from 2*PF to 2*OUT_FRAC_BITS fraction bits, truncating
  assign ext = (XW'(sum) << (2 * OUT_FRAC_BITS)) >> (2 * PF);

  always_ff @(posedge clk) begin
    if (ce) begin
      sq_len <= ext[SQW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_sr <= '0;
    end else if (ce) begin
      vld_sr <= {vld_sr[2:0], in_vld};
    end
  end

  assign vld = vld_sr[3];

endmodule

`default_nettype wire

>>> rtl/core/ssd_sqrt.sv
// ----------------------------------------------------------------------------
// ssd_sqrt
// Pipelined integer square root, one root bit per stage, floor result.
// ----------------------------------------------------------------------------
`default_nettype none

module ssd_sqrt #(
  parameter int unsigned RW = 29
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              ce,
  input  wire logic              in_vld,
  input  wire logic [2*RW-1:0]   rad,
  output logic                   vld,
  output logic [RW-1:0]          root
);

  logic [RW-1:0]   vld_sr;
  logic [2*RW-1:0] rd  [RW+1];
  logic [RW:0]     rem [RW+1];
  logic [RW-1:0]   rt  [RW+1];

  assign rd[0]  = rad;
  assign rem[0] = '0;
  assign rt[0]  = '0;

  for (genvar g = 0; g < RW; g++) begin : g_stage
    localparam int unsigned SH = 2 * (RW - 1 - g);
    logic [RW+2:0] cat, trial;
    logic          ge;
    assign cat   = {rem[g], rd[g][SH+1:SH]};
    assign trial = {1'b0, rt[g], 2'b01};
    assign ge    = cat >= trial;

    always_ff @(posedge clk) begin
      if (ce) begin
        rem[g+1] <= ge ? (RW+1)'(cat - trial) : (RW+1)'(cat);
        rt[g+1]  <= {rt[g][RW-2:0], ge};
        rd[g+1]  <= rd[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_sr <= '0;
    end else if (ce) begin
      vld_sr <= {vld_sr[RW-2:0], in_vld};
    end
  end

  assign vld  = vld_sr[RW-1];
  assign root = rt[RW];

endmodule

`default_nettype wire
